@@ rtl/csl_pkg.sv @@
package csl_pkg;

    localparam int TEXT_DEPTH = 256;
    localparam int PAT_DEPTH  = 16;

    localparam int TEXT_AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int TEXT_CW = $clog2(TEXT_DEPTH + 1);
    localparam int PAT_AW  = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int PAT_CW  = $clog2(PAT_DEPTH + 1);
    localparam int CMP_W   = (TEXT_CW > PAT_CW) ? TEXT_CW : PAT_CW;

    localparam int CH_W    = 8;
    localparam int OP_W    = 2;
    localparam int POS_W   = 9;
    localparam int STAT_W  = 2;

    localparam int RES_W       = STAT_W + 1 + POS_W + POS_W;
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - RES_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_LOCATE  = 2'd1,
        OP_PATTERN = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_TEXT_FULL = 2'd1,
        STAT_PAT_LONG  = 2'd2
    } status_t;

    // packed so that status sits in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0] text_length;
        logic [POS_W-1:0] position;
        logic             found;
        status_t          status;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOC_RD,
        S_LOC_CMP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } state_t;

endpackage

@@ rtl/csl_ram.sv @@
module csl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/char_store_locate_and_substring_unit.sv @@
// byte text store with byte locate and naive substring search
//
// input channel s_*: s_tuser carries the operation (append, locate, pattern
// byte, clear), s_tdata the byte and s_tlast marks the final pattern byte.
// result channel m_*: one result item per input item, in order.
//
// append, clear and non-final pattern bytes finish in the cycle they are
// taken and run at one item per cycle while the result register is free.
// locate walks the text store through its single read port with one shared
// byte comparator, a read state and a compare state per byte examined. the
// search on the final pattern byte uses the same port and comparator in the
// same way, restarting at the next start position after a mismatch.
// s_tready is low while a locate or search runs.
//
// the result register sits between the two sides: one more item is taken
// while a result waits on m_tready, after which s_tready drops until it moves.
// reset empties text and pattern; there is no clearing pass.
module char_store_locate_and_substring_unit
    import csl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CH_W-1:0]      s_tdata,   // ch
    input  logic [OP_W-1:0]      s_tuser,   // op
    input  logic                 s_tlast,   // pattern_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, found, position, text_length
);

    state_t              state_reg, state_next;
    logic [TEXT_CW-1:0]  text_count_reg, text_count_next;
    logic [PAT_CW-1:0]   pat_count_reg, pat_count_next;
    logic                pat_ovf_reg, pat_ovf_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [TEXT_AW-1:0]  idx_reg, idx_next;
    logic [PAT_AW-1:0]   k_reg, k_next;
    logic [PAT_CW-1:0]   plen_reg, plen_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic                s_accept;
    logic                out_free;
    op_t                 op;
    result_t             imm_res;
    logic                imm_done;
    logic [PAT_CW-1:0]   pc_v;
    logic                povf_v;

    logic                text_we;
    logic [TEXT_AW-1:0]  text_raddr;
    logic [CH_W-1:0]     text_rdata;
    logic                pat_we;
    logic [CH_W-1:0]     pat_rdata;
    logic [CH_W-1:0]     cmp_b;
    logic                cmp_eq;

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // shared byte comparator
    assign cmp_b  = (state_reg == S_LOC_CMP) ? ch_reg : pat_rdata;
    assign cmp_eq = (text_rdata == cmp_b);

    assign text_raddr = (state_reg == S_LOC_RD) ? idx_reg
                                                : TEXT_AW'(idx_reg + TEXT_AW'(k_reg));

    csl_ram #(.WIDTH(CH_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
        .aclk  (aclk),
        .we    (text_we),
        .waddr (text_count_reg[TEXT_AW-1:0]),
        .wdata (s_tdata),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    csl_ram #(.WIDTH(CH_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (pat_count_reg[PAT_AW-1:0]),
        .wdata (s_tdata),
        .raddr (k_reg),
        .rdata (pat_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        text_count_next = text_count_reg;
        pat_count_next  = pat_count_reg;
        pat_ovf_next    = pat_ovf_reg;
        ch_next         = ch_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        plen_next       = plen_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        text_we         = 1'b0;
        pat_we          = 1'b0;
        imm_done        = 1'b0;
        imm_res         = '{text_length: POS_W'(text_count_reg), position: '0,
                            found: 1'b0, status: STAT_OK};
        pc_v            = pat_count_reg;
        povf_v          = pat_ovf_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (op)
                        OP_APPEND: begin
                            imm_done = 1'b1;
                            if (text_count_reg < TEXT_CW'(TEXT_DEPTH)) begin
                                text_we             = 1'b1;
                                text_count_next     = text_count_reg + TEXT_CW'(1);
                                imm_res.text_length = POS_W'(text_count_reg + TEXT_CW'(1));
                            end else begin
                                imm_res.status = STAT_TEXT_FULL;
                            end
                        end
                        OP_LOCATE: begin
                            if (text_count_reg == '0) begin
                                imm_done = 1'b1;
                            end else begin
                                ch_next    = s_tdata;
                                idx_next   = '0;
                                res_next   = imm_res;
                                state_next = S_LOC_RD;
                            end
                        end
                        OP_PATTERN: begin
                            if (pat_count_reg < PAT_CW'(PAT_DEPTH)) begin
                                pat_we = 1'b1;
                                pc_v   = pat_count_reg + PAT_CW'(1);
                            end else begin
                                povf_v = 1'b1;
                            end
                            pat_count_next = pc_v;
                            pat_ovf_next   = povf_v;
                            if (povf_v) begin
                                imm_res.status = STAT_PAT_LONG;
                            end
                            if (s_tlast) begin
                                pat_count_next = '0;
                                pat_ovf_next   = 1'b0;
                                if (!povf_v && CMP_W'(pc_v) <= CMP_W'(text_count_reg)) begin
                                    plen_next  = pc_v;
                                    idx_next   = '0;
                                    k_next     = '0;
                                    res_next   = imm_res;
                                    state_next = S_SRCH_RD;
                                end else begin
                                    imm_done = 1'b1;
                                end
                            end else begin
                                imm_done = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            imm_done            = 1'b1;
                            text_count_next     = '0;
                            imm_res.text_length = '0;
                        end
                        default: begin
                            imm_done = 1'b1;
                        end
                    endcase
                    if (imm_done) begin
                        if (out_free) begin
                            out_next     = imm_res;
                            m_valid_next = 1'b1;
                        end else begin
                            res_next   = imm_res;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_LOC_RD: begin
                state_next = S_LOC_CMP;
            end
            S_LOC_CMP: begin
                if (cmp_eq) begin
                    res_next.found    = 1'b1;
                    res_next.position = POS_W'(TEXT_CW'(idx_reg) + TEXT_CW'(1));
                    state_next        = S_DONE;
                end else if (TEXT_CW'(idx_reg) + TEXT_CW'(1) == text_count_reg) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + TEXT_AW'(1);
                    state_next = S_LOC_RD;
                end
            end
            S_SRCH_RD: begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (cmp_eq) begin
                    if (PAT_CW'(k_reg) + PAT_CW'(1) == plen_reg) begin
                        res_next.found = 1'b1;
                        state_next     = S_DONE;
                    end else begin
                        k_next     = k_reg + PAT_AW'(1);
                        state_next = S_SRCH_RD;
                    end
                end else if (CMP_W'(idx_reg) + CMP_W'(plen_reg) == CMP_W'(text_count_reg)) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + TEXT_AW'(1);
                    k_next     = '0;
                    state_next = S_SRCH_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            text_count_reg <= '0;
            pat_count_reg  <= '0;
            pat_ovf_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            text_count_reg <= text_count_next;
            pat_count_reg  <= pat_count_next;
            pat_ovf_reg    <= pat_ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        plen_reg <= plen_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg};

endmodule

@@ rtl/csl_checker.sv @@
module csl_checker
    import csl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CH_W-1:0]      s_tdata,   // ch
    input  logic [OP_W-1:0]      s_tuser,   // op
    input  logic                 s_tlast,   // pattern_last
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata    // status, found, position, text_length
);

    result_t mres;
    logic    s_fire;

    assign mres   = result_t'(m_tdata[RES_W-1:0]);
    assign s_fire = s_tvalid && s_tready;

    // a stalled result holds its item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only one item is taken while a result waits
    a_one_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && m_tvalid && !m_tready |=> !s_tready)
        else $error("second item taken behind a stalled result");

    a_pos_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mres.position != '0 |-> mres.found)
        else $error("position without found");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mres.status == STAT_TEXT_FULL |->
            mres.text_length == POS_W'(TEXT_DEPTH))
        else $error("text full flagged below depth");

    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(mres.text_length) <= 32'(TEXT_DEPTH))
        else $error("text length beyond depth");

endmodule

bind char_store_locate_and_substring_unit csl_checker u_csl_checker (.*);
